FILE: hw/rtl/stl_pkg.sv
// Shared types and codes for the slot table allocator.
// Holds field widths, mode and status codes, and the table entry layout.
// No dependencies.
`default_nettype none

package stl_pkg;

    localparam int SLOTS_DEFAULT = 256;

    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 8;
    localparam int HANDLE_W = 32;
    localparam int LENGTH_W = 16;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [LENGTH_W-1:0] MAX_LENGTH_RESET = 16'd4096;

    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNUSED   = 2'd3;

    typedef struct packed {
        logic [STAMP_W-1:0]  stamp;
        logic [HANDLE_W-1:0] handle;
        logic [LENGTH_W-1:0] length;
    } entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/stl_entry_mem.sv
// Entry memory: timestamp, handle and length for every slot.
// One write port, one read port with registered read data; uses stl_pkg::entry_t.
`default_nettype none

module stl_entry_mem #(
    parameter int DEPTH = stl_pkg::SLOTS_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire stl_pkg::entry_t wr_data,
    input  wire logic [AW-1:0]   rd_addr,
    output stl_pkg::entry_t      rd_data
);

    stl_pkg::entry_t mem_reg [DEPTH];
    stl_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/stl_victim_scan.sv
// Slot search: walks slots 1..DEPTH-1 one per cycle through a single stamp comparator.
// Returns the lowest unused slot, else the oldest stamp (lowest index on ties).
// Depends on stl_pkg for the stamp width.
`default_nettype none

module stl_victim_scan #(
    parameter int DEPTH = stl_pkg::SLOTS_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic [AW-1:0]                    scan_addr,
    input  wire logic                        used_bit,
    input  wire logic [stl_pkg::STAMP_W-1:0] stamp_data,
    output logic                             done,
    output logic [AW-1:0]                    pick
);

    localparam logic [AW-1:0] FIRST_IDX = AW'(1);
    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);

    logic                        busy_reg, busy_next;
    logic                        issuing_reg, issuing_next;
    logic                        pipe_valid_reg, pipe_valid_next;
    logic                        best_valid_reg, best_valid_next;
    logic                        done_reg, done_next;
    logic [AW-1:0]               issue_idx_reg, issue_idx_next;
    logic [AW-1:0]               pipe_idx_reg, pipe_idx_next;
    logic                        pipe_used_reg, pipe_used_next;
    logic [AW-1:0]               best_idx_reg, best_idx_next;
    logic [stl_pkg::STAMP_W-1:0] best_stamp_reg, best_stamp_next;
    logic [AW-1:0]               pick_reg, pick_next;
    logic                        older;

    assign older = pipe_used_reg && (!best_valid_reg || (stamp_data < best_stamp_reg));

    always_comb
    begin
        busy_next       = busy_reg;
        issuing_next    = issuing_reg;
        pipe_valid_next = pipe_valid_reg;
        best_valid_next = best_valid_reg;
        done_next       = 1'b0;
        issue_idx_next  = issue_idx_reg;
        pipe_idx_next   = pipe_idx_reg;
        pipe_used_next  = pipe_used_reg;
        best_idx_next   = best_idx_reg;
        best_stamp_next = best_stamp_reg;
        pick_next       = pick_reg;

        if (start)
        begin
            busy_next       = 1'b1;
            issuing_next    = 1'b1;
            issue_idx_next  = FIRST_IDX;
            pipe_valid_next = 1'b0;
            best_valid_next = 1'b0;
        end
        else if (busy_reg)
        begin
            pipe_valid_next = issuing_reg;
            pipe_idx_next   = issue_idx_reg;
            pipe_used_next  = used_bit;
            if (issuing_reg)
            begin
                if (issue_idx_reg == LAST_IDX)
                begin
                    issuing_next = 1'b0;
                end
                else
                begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
            end

            if (pipe_valid_reg)
            begin
                if (!pipe_used_reg)
                begin
                    done_next       = 1'b1;
                    pick_next       = pipe_idx_reg;
                    busy_next       = 1'b0;
                    issuing_next    = 1'b0;
                    pipe_valid_next = 1'b0;
                end
                else
                begin
                    if (older)
                    begin
                        best_valid_next = 1'b1;
                        best_idx_next   = pipe_idx_reg;
                        best_stamp_next = stamp_data;
                    end
                    if (pipe_idx_reg == LAST_IDX)
                    begin
                        done_next       = 1'b1;
                        pick_next       = older ? pipe_idx_reg : best_idx_reg;
                        busy_next       = 1'b0;
                        issuing_next    = 1'b0;
                        pipe_valid_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            issuing_reg    <= 1'b0;
            pipe_valid_reg <= 1'b0;
            best_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            issuing_reg    <= issuing_next;
            pipe_valid_reg <= pipe_valid_next;
            best_valid_reg <= best_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_idx_reg  <= issue_idx_next;
        pipe_idx_reg   <= pipe_idx_next;
        pipe_used_reg  <= pipe_used_next;
        best_idx_reg   <= best_idx_next;
        best_stamp_reg <= best_stamp_next;
        pick_reg       <= pick_next;
    end

    assign scan_addr = issue_idx_reg;
    assign done      = done_reg;
    assign pick      = pick_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/slot_table_lru_allocator.sv
// Slot table allocator top level: command sequencer, used bits, length limit register.
// Instantiates stl_entry_mem and stl_victim_scan; uses stl_pkg.
//
// Input channel: in_valid / in_stall with mode, slot, data_handle, data_length, now.
// A beat is taken when in_valid is high and in_stall is low. One command is worked
// at a time; in_stall stays high from the accepting edge until the command's result
// has been handed to the output register.
// Output channel: out_valid / out_stall with status, slot_out, handle_out, length_out.
// One result beat per command. The output register holds a result under out_stall
// while the next command is already taken in and worked.
// Free, rejects and mode three go from decode to done; lookup adds a lookup state for
// the registered entry read, and allocate a search state. The allocate search walks slots
// 1..SLOTS-1 one per cycle through the entry memory read port and one stamp
// comparator, and ends early at the first unused slot.
// A new beat is taken the cycle after a result enters the output register.
// max_length is written through cfg_wr_en / cfg_wr_data; the user must write it
// only while idle, and the block itself does not enforce this.
// Reset clears every used bit, sets max_length to 4096 and empties the output.
// Entry contents are undefined until a slot is allocated.
`default_nettype none

module slot_table_lru_allocator #(
    parameter int SLOTS = stl_pkg::SLOTS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [stl_pkg::LENGTH_W-1:0] cfg_wr_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [stl_pkg::MODE_W-1:0]   mode,
    input  wire logic [stl_pkg::SLOT_W-1:0]   slot,
    input  wire logic [stl_pkg::HANDLE_W-1:0] data_handle,
    input  wire logic [stl_pkg::LENGTH_W-1:0] data_length,
    input  wire logic [stl_pkg::STAMP_W-1:0]  now,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [stl_pkg::STATUS_W-1:0]      status,
    output logic [stl_pkg::SLOT_W-1:0]        slot_out,
    output logic [stl_pkg::HANDLE_W-1:0]      handle_out,
    output logic [stl_pkg::LENGTH_W-1:0]      length_out
);

    localparam int AW = $clog2(SLOTS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_LOOKUP = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]                      state_reg, state_next;
    logic [stl_pkg::LENGTH_W-1:0]    max_length_reg;
    logic [SLOTS-1:0]                in_use_reg, in_use_next;
    logic                            out_valid_reg, out_valid_next;

    logic [stl_pkg::MODE_W-1:0]      mode_reg;
    logic [stl_pkg::SLOT_W-1:0]      slot_reg;
    logic [stl_pkg::HANDLE_W-1:0]    handle_reg;
    logic [stl_pkg::LENGTH_W-1:0]    length_reg;
    logic [stl_pkg::STAMP_W-1:0]     now_reg;

    logic [stl_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [stl_pkg::SLOT_W-1:0]      res_slot_reg, res_slot_next;
    logic [stl_pkg::HANDLE_W-1:0]    res_handle_reg, res_handle_next;
    logic [stl_pkg::LENGTH_W-1:0]    res_length_reg, res_length_next;

    logic [stl_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [stl_pkg::SLOT_W-1:0]      out_slot_reg, out_slot_next;
    logic [stl_pkg::HANDLE_W-1:0]    out_handle_reg, out_handle_next;
    logic [stl_pkg::LENGTH_W-1:0]    out_length_reg, out_length_next;

    logic                            accept;
    logic                            scan_start;
    logic                            scan_done;
    logic [AW-1:0]                   scan_addr;
    logic [AW-1:0]                   scan_pick;
    logic [AW-1:0]                   slot_idx;
    logic                            slot_in_range;
    logic                            mem_wr_en;
    logic [AW-1:0]                   mem_rd_addr;
    stl_pkg::entry_t                 mem_wr_data;
    stl_pkg::entry_t                 mem_rd_data;

    assign accept        = in_valid && !in_stall;
    assign in_stall      = (state_reg != ST_IDLE);
    assign slot_idx      = AW'(slot_reg);
    assign slot_in_range = (slot_reg != '0) && (32'(slot_reg) < 32'(SLOTS));
    assign mem_rd_addr   = (state_reg == ST_SCAN) ? scan_addr : slot_idx;
    assign mem_wr_en     = (state_reg == ST_SCAN) && scan_done;
    assign mem_wr_data   = '{stamp: now_reg, handle: handle_reg, length: length_reg};

    stl_entry_mem #(
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_entry_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (scan_pick),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    stl_victim_scan #(
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_victim_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_start),
        .scan_addr  (scan_addr),
        .used_bit   (in_use_reg[scan_addr]),
        .stamp_data (mem_rd_data.stamp),
        .done       (scan_done),
        .pick       (scan_pick)
    );

    always_comb
    begin
        state_next      = state_reg;
        in_use_next     = in_use_reg;
        scan_start      = 1'b0;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_handle_next = res_handle_reg;
        res_length_next = res_length_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_handle_next = out_handle_reg;
        out_length_next = out_length_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                res_status_next = stl_pkg::STATUS_OK;
                res_slot_next   = slot_reg;
                res_handle_next = '0;
                res_length_next = '0;
                state_next      = ST_DONE;
                if (mode_reg == stl_pkg::MODE_ALLOC)
                begin
                    if (length_reg >= max_length_reg)
                    begin
                        res_status_next = stl_pkg::STATUS_TOO_LONG;
                        res_slot_next   = '0;
                    end
                    else
                    begin
                        scan_start = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
                else if (mode_reg == stl_pkg::MODE_LOOKUP || mode_reg == stl_pkg::MODE_FREE)
                begin
                    if (!slot_in_range)
                    begin
                        res_status_next = stl_pkg::STATUS_RANGE;
                    end
                    else if (!in_use_reg[slot_idx])
                    begin
                        res_status_next = stl_pkg::STATUS_UNUSED;
                    end
                    else if (mode_reg == stl_pkg::MODE_LOOKUP)
                    begin
                        state_next = ST_LOOKUP;
                    end
                    else
                    begin
                        in_use_next[slot_idx] = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    in_use_next[scan_pick] = 1'b1;
                    res_slot_next          = stl_pkg::SLOT_W'(scan_pick);
                    state_next             = ST_DONE;
                end
            end
            ST_LOOKUP:
            begin
                res_handle_next = mem_rd_data.handle;
                res_length_next = mem_rd_data.length;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_handle_next = res_handle_reg;
                    out_length_next = res_length_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            max_length_reg <= stl_pkg::MAX_LENGTH_RESET;
            in_use_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_use_reg    <= in_use_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                max_length_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= mode;
            slot_reg   <= slot;
            handle_reg <= data_handle;
            length_reg <= data_length;
            now_reg    <= now;
        end
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_handle_reg <= res_handle_next;
        res_length_reg <= res_length_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_handle_reg <= out_handle_next;
        out_length_reg <= out_length_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign slot_out   = out_slot_reg;
    assign handle_out = out_handle_reg;
    assign length_out = out_length_reg;

    a_done_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |-> (state_reg == ST_SCAN))
        else $error("search finished outside an allocate");

    a_grant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && scan_done |-> (scan_pick != '0))
        else $error("slot zero granted");

    a_grant_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && scan_done |=> in_use_reg[$past(scan_pick)])
        else $error("granted slot not marked used");

    a_reject_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == stl_pkg::STATUS_TOO_LONG) |-> (slot_out == '0))
        else $error("rejected allocate reports a slot");

endmodule

`default_nettype wire

FILE: tb/sv/slot_table_lru_allocator_checker.sv
// Checker for the slot table allocator: predicts each command's reply and compares result beats.
// Watches the config, input and output channels beside the block; uses stl_pkg.
// Hands the mismatch count and the number of replies still due to the testbench top.
`default_nettype none

module slot_table_lru_allocator_checker #(
    parameter int SLOTS = stl_pkg::SLOTS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [stl_pkg::LENGTH_W-1:0] cfg_wr_data,
    input  wire logic                         in_valid,
    input  wire logic                         in_stall,
    input  wire logic [stl_pkg::MODE_W-1:0]   mode,
    input  wire logic [stl_pkg::SLOT_W-1:0]   slot,
    input  wire logic [stl_pkg::HANDLE_W-1:0] data_handle,
    input  wire logic [stl_pkg::LENGTH_W-1:0] data_length,
    input  wire logic [stl_pkg::STAMP_W-1:0]  now,
    input  wire logic                         out_valid,
    input  wire logic                         out_stall,
    input  wire logic [stl_pkg::STATUS_W-1:0] status,
    input  wire logic [stl_pkg::SLOT_W-1:0]   slot_out,
    input  wire logic [stl_pkg::HANDLE_W-1:0] handle_out,
    input  wire logic [stl_pkg::LENGTH_W-1:0] length_out,
    output int                                fail_count,
    output int                                pending
);

    typedef struct {
        logic [stl_pkg::STATUS_W-1:0] status;
        logic [stl_pkg::SLOT_W-1:0]   slot;
        logic [stl_pkg::HANDLE_W-1:0] handle;
        logic [stl_pkg::LENGTH_W-1:0] length;
    } reply_t;

    reply_t                       replies_due[$];
    reply_t                       oldest_reply;
    bit                           slot_busy[SLOTS];
    logic [stl_pkg::STAMP_W-1:0]  slot_stamp[SLOTS];
    logic [stl_pkg::HANDLE_W-1:0] slot_handle[SLOTS];
    logic [stl_pkg::LENGTH_W-1:0] slot_length[SLOTS];
    logic [stl_pkg::LENGTH_W-1:0] length_limit;
    int                           mismatches = 0;
    int                           replies_waiting = 0;

    assign fail_count = mismatches;
    assign pending    = replies_waiting;

    function automatic int choose_slot();
        int oldest;
        oldest = 1;
        for (int i = 1; i < SLOTS; i++)
        begin
            if (!slot_busy[i])
                return i;
        end
        for (int i = 2; i < SLOTS; i++)
        begin
            if (slot_stamp[i] < slot_stamp[oldest])
                oldest = i;
        end
        return oldest;
    endfunction

    function automatic reply_t apply_command(
        input logic [stl_pkg::MODE_W-1:0]   cmd,
        input logic [stl_pkg::SLOT_W-1:0]   target,
        input logic [stl_pkg::HANDLE_W-1:0] handle,
        input logic [stl_pkg::LENGTH_W-1:0] length,
        input logic [stl_pkg::STAMP_W-1:0]  stamp
    );
        reply_t reply;
        int     granted;
        reply.status = stl_pkg::STATUS_OK;
        reply.slot   = target;
        reply.handle = '0;
        reply.length = '0;
        if (cmd == stl_pkg::MODE_ALLOC)
        begin
            if (length >= length_limit)
            begin
                reply.status = stl_pkg::STATUS_TOO_LONG;
                reply.slot   = '0;
            end
            else
            begin
                granted              = choose_slot();
                slot_busy[granted]   = 1'b1;
                slot_stamp[granted]  = stamp;
                slot_handle[granted] = handle;
                slot_length[granted] = length;
                reply.slot           = stl_pkg::SLOT_W'(granted);
            end
        end
        else if (cmd == stl_pkg::MODE_LOOKUP || cmd == stl_pkg::MODE_FREE)
        begin
            if (target == 0 || int'(target) >= SLOTS)
                reply.status = stl_pkg::STATUS_RANGE;
            else if (!slot_busy[target])
                reply.status = stl_pkg::STATUS_UNUSED;
            else if (cmd == stl_pkg::MODE_LOOKUP)
            begin
                reply.handle = slot_handle[target];
                reply.length = slot_length[target];
            end
            else
            begin
                slot_busy[target]   = 1'b0;
                slot_stamp[target]  = '0;
                slot_handle[target] = '0;
                slot_length[target] = '0;
            end
        end
        return reply;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            replies_due.delete();
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_busy[i]   = 1'b0;
                slot_stamp[i]  = '0;
                slot_handle[i] = '0;
                slot_length[i] = '0;
            end
            length_limit = stl_pkg::MAX_LENGTH_RESET;
            replies_waiting <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("result beat with no command outstanding: status 0x%0h slot 0x%0h",
                           status, slot_out);
                    mismatches++;
                end
                else
                begin
                    oldest_reply = replies_due.pop_front();
                    check_field("status", 32'(oldest_reply.status), 32'(status));
                    check_field("slot_out", 32'(oldest_reply.slot), 32'(slot_out));
                    check_field("handle_out", oldest_reply.handle, handle_out);
                    check_field("length_out", 32'(oldest_reply.length), 32'(length_out));
                end
            end
            if (cfg_wr_en)
                length_limit = cfg_wr_data;
            if (in_valid && !in_stall)
                replies_due.push_back(apply_command(mode, slot, data_handle, data_length, now));
            replies_waiting <= replies_due.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/slot_table_lru_allocator_tb.sv
// Testbench top for the slot table allocator: clock, reset, command stimulus and verdict.
// Instantiates slot_table_lru_allocator and slot_table_lru_allocator_checker; uses stl_pkg.
`default_nettype none

module slot_table_lru_allocator_tb;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [stl_pkg::LENGTH_W-1:0] cfg_wr_data = '0;
    logic                         in_valid    = 1'b0;
    logic [stl_pkg::MODE_W-1:0]   mode        = stl_pkg::MODE_NONE;
    logic [stl_pkg::SLOT_W-1:0]   slot        = '0;
    logic [stl_pkg::HANDLE_W-1:0] data_handle = '0;
    logic [stl_pkg::LENGTH_W-1:0] data_length = '0;
    logic [stl_pkg::STAMP_W-1:0]  now         = '0;
    logic                         out_stall   = 1'b0;
    logic                         in_stall;
    logic                         out_valid;
    logic [stl_pkg::STATUS_W-1:0] status;
    logic [stl_pkg::SLOT_W-1:0]   slot_out;
    logic [stl_pkg::HANDLE_W-1:0] handle_out;
    logic [stl_pkg::LENGTH_W-1:0] length_out;
    int                           fail_count;
    int                           pending;
    logic                         calm         = 1'b0;
    logic [stl_pkg::LENGTH_W-1:0] length_limit = stl_pkg::MAX_LENGTH_RESET;
    logic [stl_pkg::STAMP_W-1:0]  clock_tick   = '0;

    slot_table_lru_allocator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .slot        (slot),
        .data_handle (data_handle),
        .data_length (data_length),
        .now         (now),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .slot_out    (slot_out),
        .handle_out  (handle_out),
        .length_out  (length_out)
    );

    slot_table_lru_allocator_checker i_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .slot        (slot),
        .data_handle (data_handle),
        .data_length (data_length),
        .now         (now),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .slot_out    (slot_out),
        .handle_out  (handle_out),
        .length_out  (length_out),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 18);

    initial
    begin
        #8000000;
        $display("status: fail");
        $finish;
    end

    task automatic issue(
        input logic [stl_pkg::MODE_W-1:0]   cmd,
        input logic [stl_pkg::SLOT_W-1:0]   target,
        input logic [stl_pkg::HANDLE_W-1:0] handle,
        input logic [stl_pkg::LENGTH_W-1:0] length,
        input logic [stl_pkg::STAMP_W-1:0]  stamp
    );
        if (!calm && $urandom_range(0, 99) < 18)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= cmd;
        slot        <= target;
        data_handle <= handle;
        data_length <= length;
        now         <= stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_limit(input logic [stl_pkg::LENGTH_W-1:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= value;
        length_limit = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_command(input int alloc_share);
        int                           pick;
        int                           lim;
        logic [stl_pkg::MODE_W-1:0]   cmd;
        logic [stl_pkg::SLOT_W-1:0]   target;
        logic [stl_pkg::LENGTH_W-1:0] length;
        logic [stl_pkg::STAMP_W-1:0]  stamp;
        lim  = length_limit;
        pick = $urandom_range(0, 99);
        if (pick < alloc_share)
            cmd = stl_pkg::MODE_ALLOC;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                cmd = stl_pkg::MODE_LOOKUP;
            else if (pick < 92)
                cmd = stl_pkg::MODE_FREE;
            else
                cmd = stl_pkg::MODE_NONE;
        end
        if ($urandom_range(0, 19) == 0)
            target = '0;
        else
            target = stl_pkg::SLOT_W'($urandom_range(1, stl_pkg::SLOTS_DEFAULT - 1));
        pick = $urandom_range(0, 9);
        if (lim > 0 && pick < 7)
            length = stl_pkg::LENGTH_W'($urandom_range(0, lim - 1));
        else if (lim > 0 && pick == 7)
            length = stl_pkg::LENGTH_W'(lim - 1);
        else if (pick == 8)
            length = stl_pkg::LENGTH_W'(lim);
        else
            length = stl_pkg::LENGTH_W'($urandom);
        clock_tick = clock_tick + $urandom_range(1, 100);
        pick = $urandom_range(0, 9);
        if (pick < 4)
            stamp = stl_pkg::STAMP_W'($urandom_range(0, 7));
        else if (pick < 7)
            stamp = $urandom;
        else if (pick < 9)
            stamp = clock_tick;
        else
            stamp = {stl_pkg::STAMP_W{pick[0]}};
        issue(cmd, target, $urandom, length, stamp);
    endtask

    initial
    begin
        logic [stl_pkg::LENGTH_W-1:0] phase_limit[4];
        int                           phase_items[4];
        phase_limit = '{16'hFFFF, 16'd1, 16'd0, stl_pkg::MAX_LENGTH_RESET};
        phase_items = '{300, 250, 260, 240};
        phase_limit[2] = stl_pkg::LENGTH_W'($urandom_range(2, 65534));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(stl_pkg::MODE_LOOKUP, 8'd0, 32'h1234_5678, 16'd7, 32'd9);
        issue(stl_pkg::MODE_FREE, 8'd0, '0, '0, '0);
        issue(stl_pkg::MODE_LOOKUP, 8'd255, '0, '0, '0);
        issue(stl_pkg::MODE_FREE, 8'd128, '0, '0, '0);
        issue(stl_pkg::MODE_NONE, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        issue(stl_pkg::MODE_NONE, 8'd0, '0, '0, '0);
        issue(stl_pkg::MODE_ALLOC, 8'd0, 32'hFFFF_FFFF,
              stl_pkg::LENGTH_W'(stl_pkg::MAX_LENGTH_RESET - 1), 32'hFFFF_FFFF);
        issue(stl_pkg::MODE_ALLOC, 8'd3, 32'hA5A5_5A5A, stl_pkg::MAX_LENGTH_RESET, 32'd5);
        issue(stl_pkg::MODE_ALLOC, 8'd4, 32'h5A5A_A5A5, 16'hFFFF, 32'd6);
        issue(stl_pkg::MODE_ALLOC, 8'hFF, 32'h0, 16'd0, 32'd0);
        issue(stl_pkg::MODE_LOOKUP, 8'd1, '0, '0, '0);
        issue(stl_pkg::MODE_LOOKUP, 8'd2, '0, '0, '0);
        issue(stl_pkg::MODE_FREE, 8'd1, '0, '0, '0);
        issue(stl_pkg::MODE_LOOKUP, 8'd1, '0, '0, '0);
        issue(stl_pkg::MODE_ALLOC, 8'd0, 32'hDEAD_0001, 16'd100, 32'd50);
        issue(stl_pkg::MODE_FREE, 8'd2, '0, '0, '0);
        issue(stl_pkg::MODE_FREE, 8'd2, '0, '0, '0);
        issue(stl_pkg::MODE_LOOKUP, 8'd255, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        drain();
        write_limit(16'd0);
        issue(stl_pkg::MODE_ALLOC, 8'd0, 32'h0000_0001, 16'd0, 32'd1);
        drain();
        write_limit(16'hFFFF);
        issue(stl_pkg::MODE_ALLOC, 8'd0, 32'h8000_0000, 16'hFFFE, 32'd2);
        issue(stl_pkg::MODE_ALLOC, 8'd0, 32'h8000_0001, 16'hFFFF, 32'd3);
        drain();
        write_limit(16'd1);
        issue(stl_pkg::MODE_ALLOC, 8'd0, 32'h7FFF_FFFF, 16'd0, 32'd4);
        issue(stl_pkg::MODE_ALLOC, 8'd0, 32'h7FFF_FFFE, 16'd1, 32'd5);

        for (int p = 0; p < 4; p++)
        begin
            drain();
            write_limit(phase_limit[p]);
            calm <= (p == 2);
            repeat (phase_items[p])
                random_command((p == 0) ? 85 : 55);
        end
        drain();
        calm <= 1'b0;
        repeat (stl_pkg::SLOTS_DEFAULT + 8) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
